// ===== rtl/mlqs_pkg.sv =====
package mlqs_pkg;

  localparam int MaxTasks = 32;
  localparam int IdxW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  localparam logic [1:0] ClassRt   = 2'd0;
  localparam logic [1:0] ClassSys  = 2'd1;
  localparam logic [1:0] ClassUser = 2'd2;

  localparam logic ReqArrival = 1'b0;
  localparam logic ReqTick    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_RT_READ,
    ST_SCAN,
    ST_RUN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic do_arrive;
    logic rt_read;
    logic scan_clear;
    logic scan_step;
    logic do_run;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic rt_nonempty;
    logic scan_last;
  } sts_t;

endpackage

// ===== rtl/mlqs_ctrl.sv =====
module mlqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mlqs_pkg::sts_t sts,
  output mlqs_pkg::cmd_t cmd
);

  mlqs_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlqs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      mlqs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = mlqs_pkg::ST_ARRIVE;
        end
      end
      mlqs_pkg::ST_ARRIVE: begin
        if (!sts.is_tick) begin
          cmd.do_arrive = 1'b1;
          state_nxt     = mlqs_pkg::ST_DONE;
        end else if (sts.rt_nonempty) begin
          state_nxt = mlqs_pkg::ST_RT_READ;
        end else begin
          cmd.scan_clear = 1'b1;
          state_nxt      = mlqs_pkg::ST_SCAN;
        end
      end
      mlqs_pkg::ST_RT_READ: begin
        cmd.rt_read = 1'b1;
        state_nxt   = mlqs_pkg::ST_RUN;
      end
      mlqs_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = mlqs_pkg::ST_RUN;
      end
      mlqs_pkg::ST_RUN: begin
        cmd.do_run = 1'b1;
        state_nxt  = mlqs_pkg::ST_DONE;
      end
      mlqs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mlqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mlqs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mlqs_dp.sv =====
module mlqs_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  mlqs_pkg::cmd_t cmd,
  output mlqs_pkg::sts_t sts,
  input  logic          in_req_type,
  input  logic [7:0]    in_task_id,
  input  logic [1:0]    in_task_class,
  input  logic [7:0]    in_priority_req,
  input  logic [15:0]   in_load,
  output logic          out_accepted,
  output logic          out_ran,
  output logic [7:0]    out_run_task_id,
  output logic [1:0]    out_run_class,
  output logic          out_finished,
  output logic [31:0]   out_tick_number
);

  localparam int N = mlqs_pkg::MaxTasks;
  localparam int IW = mlqs_pkg::IdxW;
  localparam int CW = mlqs_pkg::CntW;

  // request register
  logic        type_r;
  logic [7:0]  id_r, prio_r;
  logic [1:0]  cls_r;
  logic [15:0] load_r;

  // real-time fifo memory
  logic [23:0]   rt_mem [N];
  logic [IW-1:0] rt_head_r;
  logic [CW-1:0] rt_count_r;
  logic [23:0]   rt_rd_r;

  // system and user tables, flops with fixed per-entry update
  logic          sv_r [N];
  logic [7:0]    sid_r [N], sprio_r [N];
  logic [15:0]   sload_r [N];
  logic          uv_r [N];
  logic [7:0]    uid_r [N], uprio_r [N];
  logic [15:0]   uload_r [N];
  logic          uran_r [N];
  logic [31:0]   utime_r [N];

  logic [31:0] tick_r;
  logic        user_turn_r;

  // scan state
  logic [IW-1:0] scan_r;
  logic          sbest_ok_r, ubest_ok_r;
  logic [IW-1:0] sbest_r, ubest_r;

  // result registers
  logic        res_acc_r, res_ran_r, res_fin_r;
  logic [7:0]  res_id_r;
  logic [1:0]  res_cls_r;
  logic [31:0] res_tick_r;

  assign sts.is_tick     = (type_r == mlqs_pkg::ReqTick);
  assign sts.rt_nonempty = (rt_count_r != '0);
  assign sts.scan_last   = (scan_r == IW'(N - 1));

  // free slot search, priority encoders
  logic          sfree_ok, ufree_ok;
  logic [IW-1:0] sfree, ufree;
  always_comb begin
    sfree_ok = 1'b0;
    ufree_ok = 1'b0;
    sfree    = '0;
    ufree    = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!sv_r[i]) begin
        sfree_ok = 1'b1;
        sfree    = IW'(i);
      end
      if (!uv_r[i]) begin
        ufree_ok = 1'b1;
        ufree    = IW'(i);
      end
    end
  end

  logic arr_ok, arr_rt, arr_sys, arr_user;
  always_comb begin
    arr_rt   = (load_r != '0) && (cls_r == mlqs_pkg::ClassRt) && (rt_count_r < CW'(N));
    arr_sys  = (load_r != '0) && (cls_r == mlqs_pkg::ClassSys) && sfree_ok;
    arr_user = (load_r != '0) && (cls_r == mlqs_pkg::ClassUser) && ufree_ok;
    arr_ok   = arr_rt || arr_sys || arr_user;
  end

  // one comparator per class for the scan
  logic s_better, u_better;
  always_comb begin
    if (sprio_r[scan_r] != sprio_r[sbest_r])
      s_better = sprio_r[scan_r] > sprio_r[sbest_r];
    else if (sload_r[scan_r] != sload_r[sbest_r])
      s_better = sload_r[scan_r] < sload_r[sbest_r];
    else
      s_better = sid_r[scan_r] < sid_r[sbest_r];
    if (uprio_r[scan_r] != uprio_r[ubest_r])
      u_better = uprio_r[scan_r] > uprio_r[ubest_r];
    else if (uran_r[scan_r] != uran_r[ubest_r])
      u_better = !uran_r[scan_r];
    else if (uran_r[scan_r] && utime_r[scan_r] != utime_r[ubest_r])
      u_better = utime_r[scan_r] < utime_r[ubest_r];
    else
      u_better = uid_r[scan_r] < uid_r[ubest_r];
  end

  // run decision
  logic        rt_run, use_sys, any_run;
  logic [15:0] run_load, dec_load;
  logic [7:0]  run_id;
  logic [IW-1:0] rt_tail, rt_tail_after;
  always_comb begin
    rt_run   = sts.rt_nonempty;
    use_sys  = user_turn_r ? !ubest_ok_r : sbest_ok_r;
    any_run  = rt_run || sbest_ok_r || ubest_ok_r;
    if (rt_run) begin
      run_load = rt_rd_r[15:0];
      run_id   = rt_rd_r[23:16];
    end else if (use_sys) begin
      run_load = sload_r[sbest_r];
      run_id   = sid_r[sbest_r];
    end else begin
      run_load = uload_r[ubest_r];
      run_id   = uid_r[ubest_r];
    end
    dec_load      = (run_load != '0) ? run_load - 16'd1 : run_load;
    rt_tail       = IW'(rt_head_r + rt_count_r[IW-1:0]);
    rt_tail_after = rt_tail;
  end

  // fifo memory
  always_ff @(posedge clk) begin
    if (cmd.do_arrive && arr_rt) rt_mem[rt_tail] <= {id_r, load_r};
    else if (cmd.do_run && rt_run && dec_load != '0) rt_mem[rt_tail_after] <= {run_id, dec_load};
    if (cmd.rt_read) rt_rd_r <= rt_mem[rt_head_r];
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      type_r <= in_req_type;
      id_r   <= in_task_id;
      cls_r  <= in_task_class;
      prio_r <= in_priority_req;
      load_r <= in_load;
    end
    if (cmd.do_arrive) begin
      res_acc_r  <= arr_ok;
      res_ran_r  <= 1'b0;
      res_id_r   <= '0;
      res_cls_r  <= '0;
      res_fin_r  <= 1'b0;
      res_tick_r <= '0;
    end
    if (cmd.do_run) begin
      res_acc_r  <= 1'b0;
      res_ran_r  <= any_run;
      res_id_r   <= any_run ? run_id : 8'd0;
      res_cls_r  <= !any_run ? 2'd0 : rt_run ? mlqs_pkg::ClassRt :
                    use_sys ? mlqs_pkg::ClassSys : mlqs_pkg::ClassUser;
      res_fin_r  <= any_run && dec_load == '0;
      res_tick_r <= tick_r;
    end
    if (cmd.out_load) begin
      out_accepted    <= res_acc_r;
      out_ran         <= res_ran_r;
      out_run_task_id <= res_id_r;
      out_run_class   <= res_cls_r;
      out_finished    <= res_fin_r;
      out_tick_number <= res_tick_r;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_r     <= '0;
      sbest_ok_r <= 1'b0;
      ubest_ok_r <= 1'b0;
      sbest_r    <= '0;
      ubest_r    <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + IW'(1);
      if (sv_r[scan_r] && (!sbest_ok_r || s_better)) begin
        sbest_ok_r <= 1'b1;
        sbest_r    <= scan_r;
      end
      if (uv_r[scan_r] && (!ubest_ok_r || u_better)) begin
        ubest_ok_r <= 1'b1;
        ubest_r    <= scan_r;
      end
    end
  end

  // control state: counters, pointers, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_head_r   <= '0;
      rt_count_r  <= '0;
      tick_r      <= '0;
      user_turn_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        sv_r[i] <= 1'b0;
        uv_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.do_arrive && arr_rt) rt_count_r <= rt_count_r + CW'(1);
      if (cmd.do_run) begin
        tick_r <= tick_r + 32'd1;
        if (rt_run) begin
          rt_head_r <= rt_head_r + IW'(1);
          if (dec_load == '0) rt_count_r <= rt_count_r - CW'(1);
        end else if (any_run) begin
          user_turn_r <= use_sys;
        end
      end
      for (int i = 0; i < N; i++) begin
        if (cmd.do_arrive && arr_sys && sfree == IW'(i)) sv_r[i] <= 1'b1;
        if (cmd.do_arrive && arr_user && ufree == IW'(i)) uv_r[i] <= 1'b1;
        if (cmd.do_run && !rt_run && any_run && dec_load == '0) begin
          if (use_sys && sbest_r == IW'(i)) sv_r[i] <= 1'b0;
          if (!use_sys && ubest_r == IW'(i)) uv_r[i] <= 1'b0;
        end
      end
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.do_arrive && arr_sys && sfree == IW'(i)) begin
        sid_r[i]   <= id_r;
        sprio_r[i] <= prio_r;
        sload_r[i] <= load_r;
      end
      if (cmd.do_arrive && arr_user && ufree == IW'(i)) begin
        uid_r[i]   <= id_r;
        uprio_r[i] <= prio_r;
        uload_r[i] <= load_r;
        uran_r[i]  <= 1'b0;
        utime_r[i] <= '0;
      end
      if (cmd.do_run && !rt_run && any_run) begin
        if (use_sys && sbest_r == IW'(i)) sload_r[i] <= dec_load;
        if (!use_sys && ubest_r == IW'(i)) begin
          uload_r[i] <= dec_load;
          if (dec_load != '0) begin
            uran_r[i]  <= 1'b1;
            utime_r[i] <= tick_r;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/multilevel_queue_scheduler.sv =====
// Three-class task scheduler. Each request is an arrival (req_type 0) or a
// tick (req_type 1) and gives one result. Arrivals pass ARRIVE and DONE; a
// tick with real-time work waiting passes ARRIVE, RT_READ, RUN and DONE, and
// any other tick scans the 32 system and user table slots with one comparator
// per class, one slot a cycle, before RUN and DONE. One request is in flight
// at a time; the next is taken once the result sits in the output register.
module multilevel_queue_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_task_id,
  input  logic [1:0]  in_task_class,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_load,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_ran,
  output logic [7:0]  out_run_task_id,
  output logic [1:0]  out_run_class,
  output logic        out_finished,
  output logic [31:0] out_tick_number
);

  mlqs_pkg::cmd_t cmd;
  mlqs_pkg::sts_t sts;

  mlqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  mlqs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_task_id(in_task_id),
    .in_task_class(in_task_class), .in_priority_req(in_priority_req),
    .in_load(in_load), .out_accepted(out_accepted), .out_ran(out_ran),
    .out_run_task_id(out_run_task_id), .out_run_class(out_run_class),
    .out_finished(out_finished), .out_tick_number(out_tick_number)
  );

  // a result never reports both an accepted arrival and a run
  a_acc_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_ran)) else $error("accepted and ran");

  // an idle tick reports no task
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ran |-> out_run_task_id == 8'd0 && !out_finished)
    else $error("idle tick with task");

  // a taken request drops in_ready, so requests never overlap
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("request overlap");

endmodule

// ===== dv/multilevel_queue_scheduler_test.sv =====
module multilevel_queue_scheduler_test;

  typedef struct {
    logic        req_type;
    logic [7:0]  task_id;
    logic [1:0]  task_class;
    logic [7:0]  priority_req;
    logic [15:0] load;
  } request_t;

  typedef struct {
    logic        accepted;
    logic        ran;
    logic [7:0]  run_task_id;
    logic [1:0]  run_class;
    logic        finished;
    logic [31:0] tick_number;
  } outcome_t;

  typedef struct {
    bit          used;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] load;
    bit          has_run;
    logic [31:0] last_tick;
  } slot_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_task_id = '0;
  logic [1:0]  in_task_class = '0;
  logic [7:0]  in_priority_req = '0;
  logic [15:0] in_load = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic        out_ran;
  logic [7:0]  out_run_task_id;
  logic [1:0]  out_run_class;
  logic        out_finished;
  logic [31:0] out_tick_number;

  multilevel_queue_scheduler dut (.*);

  always #5 clk = ~clk;

  // scheduler shadow state
  logic [23:0] rt_ring[$];
  slot_t       sys_slots[mlqs_pkg::MaxTasks];
  slot_t       user_slots[mlqs_pkg::MaxTasks];
  logic [31:0] tick_count = '0;
  bit          user_turn = 1'b0;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  bit          stimulus_done = 1'b0;
  int          error_count = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          quiet_cycles = 0;

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit sys_wins(slot_t a, slot_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    if (a.load != b.load) return a.load < b.load;
    return a.id < b.id;
  endfunction

  function automatic bit user_wins(slot_t a, slot_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    if (a.has_run != b.has_run) return !a.has_run;
    if (a.has_run && a.last_tick != b.last_tick) return a.last_tick < b.last_tick;
    return a.id < b.id;
  endfunction

  // predict the outcome of one request and update the shadow state
  function automatic outcome_t schedule_request(request_t r);
    outcome_t o;
    int si, ui, s;
    bit pick_sys;
    logic [23:0] e;
    logic [15:0] left;
    o = '{default: '0};
    si = -1;
    ui = -1;
    s = -1;
    if (r.req_type == mlqs_pkg::ReqArrival) begin
      if (r.load == 0) return o;
      if (r.task_class == mlqs_pkg::ClassRt) begin
        if (rt_ring.size() < mlqs_pkg::MaxTasks) begin
          rt_ring.push_back({r.task_id, r.load});
          o.accepted = 1'b1;
        end
      end else if (r.task_class == mlqs_pkg::ClassSys ||
                   r.task_class == mlqs_pkg::ClassUser) begin
        for (int i = mlqs_pkg::MaxTasks - 1; i >= 0; i--) begin
          if (r.task_class == mlqs_pkg::ClassSys ? !sys_slots[i].used :
              !user_slots[i].used) s = i;
        end
        if (s >= 0) begin
          if (r.task_class == mlqs_pkg::ClassSys)
            sys_slots[s] = '{1'b1, r.task_id, r.priority_req, r.load, 1'b0, '0};
          else
            user_slots[s] = '{1'b1, r.task_id, r.priority_req, r.load, 1'b0, '0};
          o.accepted = 1'b1;
        end
      end
      return o;
    end
    o.tick_number = tick_count;
    tick_count++;
    if (rt_ring.size() > 0) begin
      e = rt_ring.pop_front();
      left = e[15:0] - 16'd1;
      o.ran = 1'b1;
      o.run_task_id = e[23:16];
      o.run_class = mlqs_pkg::ClassRt;
      if (left == 0) o.finished = 1'b1;
      else rt_ring.push_back({e[23:16], left});
      return o;
    end
    for (int i = 0; i < mlqs_pkg::MaxTasks; i++) begin
      if (sys_slots[i].used && (si < 0 || sys_wins(sys_slots[i], sys_slots[si]))) si = i;
      if (user_slots[i].used && (ui < 0 || user_wins(user_slots[i], user_slots[ui]))) ui = i;
    end
    if (si < 0 && ui < 0) return o;
    pick_sys = user_turn ? (ui < 0) : (si >= 0);
    user_turn = pick_sys;
    o.ran = 1'b1;
    if (pick_sys) begin
      sys_slots[si].load--;
      o.run_task_id = sys_slots[si].id;
      o.run_class = mlqs_pkg::ClassSys;
      if (sys_slots[si].load == 0) begin
        o.finished = 1'b1;
        sys_slots[si].used = 1'b0;
      end
    end else begin
      user_slots[ui].load--;
      o.run_task_id = user_slots[ui].id;
      o.run_class = mlqs_pkg::ClassUser;
      if (user_slots[ui].load == 0) begin
        o.finished = 1'b1;
        user_slots[ui].used = 1'b0;
      end else begin
        user_slots[ui].has_run = 1'b1;
        user_slots[ui].last_tick = o.tick_number;
      end
    end
    return o;
  endfunction

  function automatic request_t arrival(logic [1:0] cls, logic [7:0] id,
                                       logic [7:0] prio, logic [15:0] ld);
    return '{mlqs_pkg::ReqArrival, id, cls, prio, ld};
  endfunction

  function automatic request_t tick_request();
    request_t r;
    r.req_type = mlqs_pkg::ReqTick;
    r.task_id = 8'($urandom);
    r.task_class = 2'($urandom);
    r.priority_req = 8'($urandom);
    r.load = 16'($urandom);
    return r;
  endfunction

  // stimulus
  initial begin
    int kind;
    request_t r;
    // directed: idle tick, rejects, extremes, ties, each class
    pending_requests.push_back(tick_request());
    pending_requests.push_back(arrival(mlqs_pkg::ClassRt, 8'hff, 8'h00, 16'h0000));
    pending_requests.push_back(arrival(2'd3, 8'h10, 8'h10, 16'h0005));
    pending_requests.push_back(arrival(mlqs_pkg::ClassRt, 8'h00, 8'hff, 16'h0002));
    pending_requests.push_back(arrival(mlqs_pkg::ClassSys, 8'hff, 8'hff, 16'hffff));
    pending_requests.push_back(arrival(mlqs_pkg::ClassSys, 8'h01, 8'h80, 16'h0001));
    pending_requests.push_back(arrival(mlqs_pkg::ClassSys, 8'h01, 8'h80, 16'h0001));
    pending_requests.push_back(arrival(mlqs_pkg::ClassUser, 8'haa, 8'h55, 16'h0003));
    pending_requests.push_back(arrival(mlqs_pkg::ClassUser, 8'h55, 8'h55, 16'h0003));
    for (int i = 0; i < 12; i++) pending_requests.push_back(tick_request());
    // fill the real-time ring past capacity
    for (int i = 0; i < mlqs_pkg::MaxTasks + 2; i++)
      pending_requests.push_back(arrival(mlqs_pkg::ClassRt, i[7:0], 8'h00, 16'h0001));
    for (int i = 0; i < mlqs_pkg::MaxTasks + 1; i++) pending_requests.push_back(tick_request());
    // fill system and user tables past capacity
    for (int i = 0; i < mlqs_pkg::MaxTasks + 2; i++) begin
      pending_requests.push_back(arrival(mlqs_pkg::ClassSys, 8'($urandom),
                                         8'($urandom_range(0, 3)),
                                         16'($urandom_range(1, 4))));
      pending_requests.push_back(arrival(mlqs_pkg::ClassUser, 8'($urandom),
                                         8'($urandom_range(0, 3)),
                                         16'($urandom_range(1, 4))));
    end
    // random traffic, mostly ticks with small loads and few priorities
    for (int n = 0; n < 1800; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) r = tick_request();
      else begin
        r.req_type = mlqs_pkg::ReqArrival;
        r.task_id = 8'($urandom);
        r.task_class = (kind < 58) ? 2'd3 : 2'($urandom_range(0, 2));
        r.priority_req = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, 3));
        r.load = (kind < 61) ? 16'h0000 :
                 (kind < 63) ? 16'($urandom) : 16'($urandom_range(1, 6));
      end
      pending_requests.push_back(r);
    end
    stimulus_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    request_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_outcomes.push_back(schedule_request('{in_req_type, in_task_id,
          in_task_class, in_priority_req, in_load}));
        in_gap = gap_length();
      end
      if (!in_valid || in_ready) begin
        if (in_gap == 0 && pending_requests.size() > 0) begin
          r = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= r.req_type;
          in_task_id <= r.task_id;
          in_task_class <= r.task_class;
          in_priority_req <= r.priority_req;
          in_load <= r.load;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // monitor and result checks
  always @(posedge clk) begin
    outcome_t x;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got acc=%0d ran=%0d id=%0d %s",
            $time, out_accepted, out_ran, out_run_task_id,
            $sformatf("cls=%0d fin=%0d tick=%0d", out_run_class, out_finished,
                      out_tick_number));
          error_count++;
        end else begin
          x = expected_outcomes.pop_front();
          if (out_accepted !== x.accepted || out_ran !== x.ran ||
              out_run_task_id !== x.run_task_id || out_run_class !== x.run_class ||
              out_finished !== x.finished || out_tick_number !== x.tick_number) begin
            $display("%0t: mismatch, expected %p, got acc=%0d ran=%0d id=%0d %s",
              $time, x, out_accepted, out_ran, out_run_task_id,
              $sformatf("cls=%0d fin=%0d tick=%0d", out_run_class, out_finished,
                        out_tick_number));
            error_count++;
          end
        end
        out_gap = gap_length();
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // reset, watchdog and end of run
  initial begin
    int drain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    drain = 0;
    while (drain < 100) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 2000) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (stimulus_done && pending_requests.size() == 0 && !in_valid &&
          expected_outcomes.size() == 0) drain++;
    end
    if (error_count == 0 && !out_valid) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
